### sv/tec_pkg.sv
// Shared types and constants for the texture environment combine unit.
package tec_pkg;

  localparam int unsigned CH_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NUM_CH = 4;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_BLEND = 3'd1;
  localparam logic [2:0] MODE_DECAL = 3'd2;
  localparam logic [2:0] MODE_MODULATE = 3'd3;
  localparam logic [2:0] MODE_REPLACE = 3'd4;

  localparam logic [2:0] FMT_LUM = 3'd0;
  localparam logic [2:0] FMT_RGB = 3'd1;
  localparam logic [2:0] FMT_ALPHA = 3'd2;
  localparam logic [2:0] FMT_LUM_ALPHA = 3'd3;
  localparam logic [2:0] FMT_RGBA = 3'd4;

  localparam logic [2:0] REG_STAGE_EN = 3'd0;
  localparam logic [2:0] REG_TEX_INCOMPLETE = 3'd1;
  localparam logic [2:0] REG_ENV_MODE = 3'd2;
  localparam logic [2:0] REG_BASE_FORMAT = 3'd3;
  localparam logic [2:0] REG_ENV_RED = 3'd4;
  localparam logic [2:0] REG_ENV_GREEN = 3'd5;
  localparam logic [2:0] REG_ENV_BLUE = 3'd6;

  typedef enum logic [2:0] {
    LOP_KEEP,
    LOP_ADD,
    LOP_MUL,
    LOP_LERP,
    LOP_TEX
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     use_env;
    logic     use_tex_alpha;
  } lane_ctrl_t;

endpackage

### sv/tec_lane.sv
// One color channel of the combine: saturating add, scaled multiply, lerp or select.
module tec_lane (
  input  logic [15:0]        frag,
  input  logic [15:0]        tex,
  input  logic [15:0]        env,
  input  logic [15:0]        tex_alpha,
  input  tec_pkg::lane_ctrl_t ctrl,
  output logic [15:0]        result
);
  import tec_pkg::*;

  logic [15:0]        target;
  logic [15:0]        weight;
  logic [16:0]        weight_exp;
  logic signed [16:0] factor;
  logic signed [35:0] prod;
  logic [15:0]        scaled;
  logic [16:0]        sum;

  always_comb begin
    target = ctrl.use_env ? env : tex;
    weight = ctrl.use_tex_alpha ? tex_alpha : tex;
    weight_exp = {1'b0, weight} + {16'd0, weight[15]};
    if (ctrl.op == LOP_LERP) begin
      factor = $signed({1'b0, target}) - $signed({1'b0, frag});
    end else begin
      factor = $signed({1'b0, frag});
    end
    prod = $signed({factor[16], factor}) * $signed({1'b0, weight_exp});
    scaled = prod[31:16];
    sum = {1'b0, frag} + {1'b0, tex};
    case (ctrl.op)
      LOP_ADD:  result = sum[16] ? 16'hFFFF : sum[15:0];
      LOP_MUL:  result = scaled;
      LOP_LERP: result = frag + scaled;
      LOP_TEX:  result = tex;
      default:  result = frag;
    endcase
  end

endmodule

### sv/texture_env_combine_unit.sv
// Top level of the texture environment combine unit: config registers, decode, pipeline.
//
// channel  dir  payload
// s_*      in   frag_red..frag_alpha, tex_red..tex_alpha (16 bits each)
// m_*      out  out_red..out_alpha (16 bits), byte_red..byte_alpha (8 bits)
// cfg_*    in   cfg_index selects register, cfg_data carries its value
//
// Each beat passes an input register, then one pass through the four channel
// lanes (one 18x18 multiply and one add each) into the result register. One beat is
// accepted per cycle unless both stages are full and stalled; a stalled result holds while the input
// register keeps its beat. Reset empties both stages and restores the config defaults.
module texture_env_combine_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frag_red, frag_green, frag_blue, frag_alpha, tex_red, tex_green, tex_blue, tex_alpha
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_red, out_green, out_blue, out_alpha, byte_red, byte_green, byte_blue, byte_alpha
  output logic [95:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import tec_pkg::*;

  logic        stage_en;
  logic        tex_incomplete;
  logic [2:0]  env_mode;
  logic [2:0]  base_format;
  logic [15:0] env_red;
  logic [15:0] env_green;
  logic [15:0] env_blue;

  logic              in_valid;
  logic [3:0][15:0]  in_frag;
  logic [3:0][15:0]  in_tex;
  logic              out_valid;
  logic [3:0][15:0]  out_chan;
  logic              advance;

  logic [2:0]        fmt_eff;
  lane_ctrl_t        ctrl [4];
  logic [3:0][15:0]  env_vec;
  logic [3:0][15:0]  lane_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_en <= 1'b0;
      tex_incomplete <= 1'b0;
      env_mode <= MODE_MODULATE;
      base_format <= FMT_RGBA;
      env_red <= '0;
      env_green <= '0;
      env_blue <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STAGE_EN:       stage_en <= cfg_data[0];
        REG_TEX_INCOMPLETE: tex_incomplete <= cfg_data[0];
        REG_ENV_MODE:       env_mode <= cfg_data[2:0];
        REG_BASE_FORMAT:    base_format <= cfg_data[2:0];
        REG_ENV_RED:        env_red <= cfg_data;
        REG_ENV_GREEN:      env_green <= cfg_data;
        REG_ENV_BLUE:       env_blue <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_frag <= s_tdata[63:0];
      in_tex <= s_tdata[127:64];
    end
  end

  always_comb begin
    if (tex_incomplete || base_format > FMT_RGBA) begin
      fmt_eff = FMT_RGBA;
    end else begin
      fmt_eff = base_format;
    end
    for (int i = 0; i < 4; i++) begin
      ctrl[i] = '{op: LOP_KEEP, use_env: 1'b0, use_tex_alpha: 1'b0};
    end
    if (stage_en) begin
      case (env_mode)
        MODE_ADD: begin
          for (int i = 0; i < 4; i++) ctrl[i].op = LOP_ADD;
        end
        MODE_BLEND: begin
          for (int i = 0; i < 3; i++) begin
            ctrl[i].op = LOP_LERP;
            ctrl[i].use_env = 1'b1;
          end
          ctrl[3].op = LOP_MUL;
        end
        MODE_DECAL: begin
          for (int i = 0; i < 3; i++) begin
            ctrl[i].op = LOP_LERP;
            ctrl[i].use_tex_alpha = 1'b1;
          end
        end
        MODE_MODULATE: begin
          if (fmt_eff != FMT_ALPHA) begin
            for (int i = 0; i < 3; i++) ctrl[i].op = LOP_MUL;
          end
          ctrl[3].op = LOP_MUL;
        end
        MODE_REPLACE: begin
          if (fmt_eff inside {FMT_LUM, FMT_RGB}) begin
            for (int i = 0; i < 3; i++) ctrl[i].op = LOP_TEX;
          end else if (fmt_eff == FMT_ALPHA) begin
            ctrl[3].op = LOP_TEX;
          end else begin
            for (int i = 0; i < 4; i++) ctrl[i].op = LOP_TEX;
          end
        end
        default: ;
      endcase
    end
  end

  assign env_vec = {16'd0, env_blue, env_green, env_red};

  for (genvar g = 0; g < 4; g++) begin : g_lane
    tec_lane u_lane (
      .frag      (in_frag[g]),
      .tex       (in_tex[g]),
      .env       (env_vec[g]),
      .tex_alpha (in_tex[3]),
      .ctrl      (ctrl[g]),
      .result    (lane_result[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_chan <= lane_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {out_chan[3][15:8], out_chan[2][15:8], out_chan[1][15:8],
                    out_chan[0][15:8], out_chan[3], out_chan[2], out_chan[1],
                    out_chan[0]};

endmodule

### sv/tec_checker.sv
// Port-level checks for the texture environment combine unit, bound to the top level.
module tec_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_byte_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:64] == m_tdata[15:8] && m_tdata[79:72] == m_tdata[31:24]
                 && m_tdata[87:80] == m_tdata[47:40] && m_tdata[95:88] == m_tdata[63:56])
    else $error("byte fields differ from channel high bytes");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result stage is empty");

endmodule

bind texture_env_combine_unit tec_checker u_tec_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the texture environment combine unit.
module tb_top;
  import tec_pkg::*;

  typedef struct packed {
    logic [3:0][15:0] texel;
    logic [3:0][15:0] frag;
  } fragment_beat_t;

  typedef struct packed {
    logic [3:0][7:0]  narrow;
    logic [3:0][15:0] wide;
  } color_result_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  fragment_beat_t s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  color_result_t  m_tdata;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [15:0]    cfg_data = '0;

  logic             stage_en = 1'b0;
  logic             tex_incomplete = 1'b0;
  logic [2:0]       env_mode = MODE_MODULATE;
  logic [2:0]       base_format = FMT_RGBA;
  logic [2:0][15:0] env_rgb = '0;

  fragment_beat_t pending_fragments[$];
  color_result_t  expected_colors[$];
  color_result_t  want;
  int             beats_queued = 0;
  int             beats_accepted = 0;
  int             errors = 0;
  int             gap_max = 3;
  int             gap_left = 0;
  int             burst_left = 0;
  int             stall_pct = 30;
  logic           hold_off = 1'b0;
  string          lane_name[4] = '{"red", "green", "blue", "alpha"};

  texture_env_combine_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] scale_mul(logic [15:0] a, logic [15:0] b);
    logic [16:0] w;
    logic [32:0] p;
    w = {1'b0, b} + 17'(b[15]);
    p = 33'(a) * 33'(w);
    return p[31:16];
  endfunction

  function automatic logic [15:0] lerp_toward(logic [15:0] f, logic [15:0] s, logic [15:0] w);
    logic signed [35:0] d;
    logic signed [35:0] p;
    logic signed [35:0] r;
    d = $signed({20'd0, s}) - $signed({20'd0, f});
    p = d * $signed({19'd0, {1'b0, w} + 17'(w[15])});
    r = $signed({20'd0, f}) + (p >>> 16);
    return r[15:0];
  endfunction

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic color_result_t predict_combine(fragment_beat_t b);
    color_result_t r;
    logic [2:0]    fmt;
    r.wide = b.frag;
    if (stage_en) begin
      fmt = (tex_incomplete || base_format > FMT_RGBA) ? FMT_RGBA : base_format;
      case (env_mode)
        MODE_ADD: begin
          for (int i = 0; i < 4; i++) r.wide[i] = sat_sum(b.frag[i], b.texel[i]);
        end
        MODE_BLEND: begin
          for (int i = 0; i < 3; i++) r.wide[i] = lerp_toward(b.frag[i], env_rgb[i], b.texel[i]);
          r.wide[3] = scale_mul(b.frag[3], b.texel[3]);
        end
        MODE_DECAL: begin
          for (int i = 0; i < 3; i++) r.wide[i] = lerp_toward(b.frag[i], b.texel[i], b.texel[3]);
        end
        MODE_MODULATE: begin
          if (fmt != FMT_ALPHA)
            for (int i = 0; i < 3; i++) r.wide[i] = scale_mul(b.frag[i], b.texel[i]);
          r.wide[3] = scale_mul(b.frag[3], b.texel[3]);
        end
        MODE_REPLACE: begin
          if (fmt == FMT_LUM || fmt == FMT_RGB) begin
            for (int i = 0; i < 3; i++) r.wide[i] = b.texel[i];
          end else if (fmt == FMT_ALPHA) begin
            r.wide[3] = b.texel[3];
          end else begin
            r.wide = b.texel;
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < 4; i++) r.narrow[i] = r.wide[i][15:8];
    return r;
  endfunction

  function automatic logic [15:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic fragment_beat_t random_fragment();
    fragment_beat_t b;
    for (int i = 0; i < 4; i++) begin
      b.frag[i] = pick_channel();
      b.texel[i] = pick_channel();
    end
    return b;
  endfunction

  function automatic fragment_beat_t flat_fragment(logic [15:0] f, logic [15:0] t);
    fragment_beat_t b;
    b.frag = {4{f}};
    b.texel = {4{t}};
    return b;
  endfunction

  task automatic queue_fragment(input fragment_beat_t b);
    pending_fragments.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_edge_trio();
    queue_fragment(flat_fragment(16'hFFFF, 16'hFFFF));
    queue_fragment(flat_fragment(16'h0000, 16'hFFFF));
    queue_fragment(flat_fragment(16'hFFFF, 16'h8000));
  endtask

  task automatic drain_pipeline();
    do @(posedge clk);
    while (beats_accepted != beats_queued || expected_colors.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_stage(input logic en, input logic inc, input logic [2:0] mode,
                               input logic [2:0] fmt, input logic [15:0] red,
                               input logic [15:0] green, input logic [15:0] blue);
    logic [6:0][15:0] value;
    value[REG_STAGE_EN] = {15'd0, en};
    value[REG_TEX_INCOMPLETE] = {15'd0, inc};
    value[REG_ENV_MODE] = {13'd0, mode};
    value[REG_BASE_FORMAT] = {13'd0, fmt};
    value[REG_ENV_RED] = red;
    value[REG_ENV_GREEN] = green;
    value[REG_ENV_BLUE] = blue;
    for (int r = REG_STAGE_EN; r <= REG_ENV_BLUE; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data <= value[r];
      do @(posedge clk);
      while (!cfg_ready);
      case (3'(r))
        REG_STAGE_EN:       stage_en = value[r][0];
        REG_TEX_INCOMPLETE: tex_incomplete = value[r][0];
        REG_ENV_MODE:       env_mode = value[r][2:0];
        REG_BASE_FORMAT:    base_format = value[r][2:0];
        REG_ENV_RED:        env_rgb[0] = value[r];
        REG_ENV_GREEN:      env_rgb[1] = value[r];
        REG_ENV_BLUE:       env_rgb[2] = value[r];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // driver: bursts with random gaps, hold the beat until accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_colors.push_back(predict_combine(s_tdata));
        beats_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || pending_fragments.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_fragments.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
          end
        end
      end
    end
  end

  // monitor: compare each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_colors.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
        end else begin
          want = expected_colors.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (m_tdata.wide[i] !== want.wide[i]) begin
              errors++;
              $display("%0t: out_%s expected %h actual %h", $time, lane_name[i],
                       want.wide[i], m_tdata.wide[i]);
            end
            if (m_tdata.narrow[i] !== want.narrow[i]) begin
              errors++;
              $display("%0t: byte_%s expected %h actual %h", $time, lane_name[i],
                       want.narrow[i], m_tdata.narrow[i]);
            end
          end
        end
      end
      m_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // hold off the receiver for a long stretch mid-run
  initial begin
    wait (beats_accepted >= 700);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("texture_env_combine_unit verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_edge_trio();
    drain_pipeline();
    program_stage(1'b1, 1'b0, MODE_ADD, FMT_RGBA, 16'h0000, 16'h0000, 16'h0000);
    queue_edge_trio();
    drain_pipeline();
    program_stage(1'b1, 1'b0, MODE_BLEND, FMT_RGB, 16'hFFFF, 16'h0000, 16'h8000);
    queue_edge_trio();
    drain_pipeline();
    program_stage(1'b1, 1'b0, MODE_DECAL, FMT_RGBA, 16'h0000, 16'h0000, 16'h0000);
    queue_edge_trio();
    drain_pipeline();
    program_stage(1'b1, 1'b0, MODE_MODULATE, FMT_ALPHA, 16'h0000, 16'h0000, 16'h0000);
    queue_edge_trio();
    drain_pipeline();
    program_stage(1'b1, 1'b1, MODE_MODULATE, FMT_ALPHA, 16'h0000, 16'h0000, 16'h0000);
    queue_edge_trio();
    drain_pipeline();
    program_stage(1'b1, 1'b0, MODE_REPLACE, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_edge_trio();
    drain_pipeline();
    program_stage(1'b1, 1'b0, '1, FMT_RGBA, 16'h1234, 16'h5678, 16'h9ABC);
    queue_edge_trio();
    drain_pipeline();

    for (int p = 0; p < 10; p++) begin
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 12);
      stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 70);
      program_stage(p != 3, $urandom_range(0, 3) == 0, 3'(p % 5), 3'($urandom_range(0, 7)),
                    pick_channel(), pick_channel(), pick_channel());
      repeat (130) queue_fragment(random_fragment());
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("texture_env_combine_unit verification clean");
    end else begin
      $display("texture_env_combine_unit verification failed");
    end
    $finish;
  end

endmodule
